// ===== design/beat_interval_rate_averager_assert.svh =====
`ifndef BEAT_INTERVAL_RATE_AVERAGER_ASSERT_SVH
`define BEAT_INTERVAL_RATE_AVERAGER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BIRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BIRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bira_pkg.sv =====
package bira_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int BPM_W       = 8;
  localparam int RATE_W      = 8;
  localparam int AVG_W       = 11;
  localparam int DIV_W       = 16;
  localparam int DIV_CNT_W   = 4;
  localparam int PC_W        = 3;

  localparam logic [IN_TDATA_W-1:0] MIN_INTERVAL   = 32'd236;
  localparam logic [IN_TDATA_W-1:0] MAX_INTERVAL   = 32'd2999;
  localparam logic [DIV_W-1:0]      RATE_NUMERATOR = 16'd60000;

  localparam logic [BPM_W-1:0] ALARM_LOW_RESET  = 8'd40;
  localparam logic [BPM_W-1:0] ALARM_HIGH_RESET = 8'd160;

  // register select, taken from paddr bit 2
  localparam logic REG_ALARM_LOW  = 1'b0;
  localparam logic REG_ALARM_HIGH = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_IDLE      = 3'd0;
  localparam pc_t STEP_CHECK     = 3'd1;
  localparam pc_t STEP_RATE_LOAD = 3'd2;
  localparam pc_t STEP_RATE_WAIT = 3'd3;
  localparam pc_t STEP_UPDATE    = 3'd4;
  localparam pc_t STEP_EMIT      = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_DIV_RATE,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_SKIP_REJECT,
    COND_WAIT_DIV,
    COND_WAIT_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic reject;
    logic div_busy;
    logic out_blocked;
  } seq_stat_t;

  typedef struct packed {
    op_t  op;
    logic en;
    logic in_ready;
  } seq_ctl_t;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      STEP_IDLE:      w = '{op: OP_CAPTURE, cond: COND_WAIT_IN,     target: STEP_IDLE};
      STEP_CHECK:     w = '{op: OP_NOP,     cond: COND_SKIP_REJECT, target: STEP_EMIT};
      STEP_RATE_LOAD: w = '{op: OP_DIV_RATE, cond: COND_NEXT,       target: STEP_IDLE};
      STEP_RATE_WAIT: w = '{op: OP_NOP,     cond: COND_WAIT_DIV,    target: STEP_IDLE};
      STEP_UPDATE:    w = '{op: OP_UPDATE,  cond: COND_NEXT,        target: STEP_IDLE};
      STEP_EMIT:      w = '{op: OP_EMIT,    cond: COND_WAIT_OUT,    target: STEP_IDLE};
      default:        w = '{op: OP_NOP,     cond: COND_NEXT,        target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/beat_interval_rate_averager.sv =====
// beat interval rate averager
// in channel: one transaction per detected beat, in_tdata is the 32-bit ms timestamp.
// the interval to the previous beat (wrapping) gives rate = 60000 / interval; a beat
// with an interval of 236 to 2999 ms is stored in a RING_DEPTH-entry ring.
// out channel: one transaction per beat with the scaled average, accepted flag, alarm.
// cfg port: apb-style, alarm_low_bpm at 0x0, alarm_high_bpm at 0x4, pready always high.
// a small microcode program runs a 16-step radix-2 divider once per stored beat for
// the rate; 8 * sum / RING_DEPTH is a multiply by a constant reciprocal.
// sequence: capture, check, then for a stored beat divider load, divider wait and update,
// then emit; a rejected beat goes straight from check to emit. out_tvalid and in_tready
// rise together, as the emit step loads the output register and returns to idle.
// a result waiting on out_tready does not stop the next beat from being accepted;
// that beat's result waits at its last step until the output register is free.
// reset: alarm limits to 40 and 160 bpm, ring, sum, slot and last timestamp to zero.
module beat_interval_rate_averager import bira_pkg::*; #(
  parameter int RING_DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // [31:0] beat_time_ms
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,    // [10:0] avg_bpm_x8, [11] accepted, [12] rate_alarm
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int SUM_W  = $clog2(255 * RING_DEPTH + 1);
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int PROD_W = 2 * DIV_W + 1;
  // floor(x * AVG_RECIP >> AVG_SHIFT) equals floor(x / RING_DEPTH) for any 16-bit x
  localparam int AVG_SHIFT = DIV_W + SLOT_W;
  localparam logic [DIV_W:0] AVG_RECIP =
    (DIV_W+1)'(((64'd1 << AVG_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  logic [BPM_W-1:0]      alarm_low_r, alarm_high_r;
  logic [IN_TDATA_W-1:0] last_time_r;
  logic [IN_TDATA_W-1:0] interval_r;
  logic [RATE_W-1:0]     ring_r [RING_DEPTH];
  logic [SLOT_W-1:0]     slot_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  acc_r;
  logic                  out_tvalid_r;
  logic [AVG_W-1:0]      out_avg_r;
  logic                  out_acc_r;
  logic                  out_alarm_r;

  seq_stat_t        stat;
  seq_ctl_t         ctl;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_busy;
  logic [DIV_W-1:0] div_quo;
  logic [RATE_W-1:0] rate;
  logic [DIV_W-1:0]  avg_num;
  logic [PROD_W-1:0] avg_prod;
  logic [AVG_W-1:0]  avg_x8;
  logic [SUM_W-1:0] lo_lim, hi_lim;
  logic             alarm;
  logic             cfg_wr;

  assign stat.in_valid    = in_tvalid;
  assign stat.reject      = (interval_r < MIN_INTERVAL) || (interval_r > MAX_INTERVAL);
  assign stat.div_busy    = div_busy;
  assign stat.out_blocked = out_tvalid_r && !out_tready;

  bira_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  assign div_start    = ctl.en && (ctl.op == OP_DIV_RATE);
  assign div_dividend = RATE_NUMERATOR;
  assign div_divisor  = interval_r[DIV_W-1:0];

  bira_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign rate     = div_quo[RATE_W-1:0];
  assign avg_num  = DIV_W'({sum_r, 3'b000});
  assign avg_prod = PROD_W'(avg_num) * PROD_W'(AVG_RECIP);
  assign avg_x8   = AVG_W'(avg_prod >> AVG_SHIFT);
  assign lo_lim = SUM_W'(alarm_low_r) * SUM_W'(RING_DEPTH);
  assign hi_lim = SUM_W'(alarm_high_r) * SUM_W'(RING_DEPTH);
  assign alarm  = (sum_r != '0) && ((sum_r < lo_lim) || (sum_r > hi_lim));

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_low_r  <= ALARM_LOW_RESET;
      alarm_high_r <= ALARM_HIGH_RESET;
      last_time_r  <= '0;
      slot_r       <= '0;
      sum_r        <= '0;
      acc_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_ALARM_HIGH) begin
          alarm_high_r <= cfg_pwdata[BPM_W-1:0];
        end else begin
          alarm_low_r <= cfg_pwdata[BPM_W-1:0];
        end
      end
      if (ctl.en && (ctl.op == OP_EMIT)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (ctl.en) begin
        case (ctl.op)
          OP_CAPTURE: begin
            last_time_r <= in_tdata;
            interval_r  <= in_tdata - last_time_r;
            acc_r       <= 1'b0;
          end
          OP_UPDATE: begin
            sum_r          <= sum_r - SUM_W'(ring_r[slot_r]) + SUM_W'(rate);
            ring_r[slot_r] <= rate;
            acc_r          <= 1'b1;
            if (slot_r == SLOT_W'(RING_DEPTH - 1)) begin
              slot_r <= '0;
            end else begin
              slot_r <= slot_r + 1'b1;
            end
          end
          OP_EMIT: begin
            out_avg_r    <= avg_x8;
            out_acc_r    <= acc_r;
            out_alarm_r  <= alarm;
          end
          default: ;
        endcase
      end
    end
  end

  assign in_tready  = ctl.in_ready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_alarm_r, out_acc_r, out_avg_r});

  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_W'((cfg_paddr[2] == REG_ALARM_HIGH) ? alarm_high_r : alarm_low_r);

endmodule

// ===== design/bira_div.sv =====
module bira_div import bira_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;

  // one restoring step per cycle, msb first
  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIV_W]) begin
        rem_nxt = diff[DIV_W-1:0];
      end else begin
        rem_nxt = shifted[DIV_W-1:0];
      end
      quo_nxt = {quo_r[DIV_W-2:0], ~diff[DIV_W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== design/bira_seq.sv =====
module bira_seq import bira_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat_i,
  output seq_ctl_t  ctl_o
);

  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   hold;
  logic   jump;

  assign uw = ucode_rom(pc_r);

  always_comb begin
    hold = 1'b0;
    jump = 1'b0;
    unique case (uw.cond)
      COND_NEXT:        ;
      COND_WAIT_IN:     hold = !stat_i.in_valid;
      COND_SKIP_REJECT: jump = stat_i.reject;
      COND_WAIT_DIV:    hold = stat_i.div_busy;
      COND_WAIT_OUT: begin
        hold = stat_i.out_blocked;
        jump = 1'b1;
      end
      default:          ;
    endcase
    if (hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl_o.op       = uw.op;
  assign ctl_o.en       = !hold;
  assign ctl_o.in_ready = (pc_r == STEP_IDLE);

endmodule

// ===== design/bira_chk.sv =====
`include "beat_interval_rate_averager_assert.svh"

module bira_chk import bira_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `BIRA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "out transaction changed while stalled")
  `BIRA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "in_tready high right after a beat was taken")
  `BIRA_ASSERT_NOW(a_stored_nonzero, out_tvalid && out_tdata[11], out_tdata[10:0] != 11'd0, "stored beat but average is zero")
  `BIRA_ASSERT_NOW(a_alarm_nonzero, out_tvalid && out_tdata[12], out_tdata[10:0] != 11'd0, "alarm raised on an empty average")

endmodule

bind beat_interval_rate_averager bira_chk u_bira_chk (.*);
